### src/mvta_pkg.sv
// Shared types, constants and saturation helpers for the tangent accumulator.
`default_nettype none

package mvta_pkg;

   // Default sizes handed to the top level.
   localparam int MAX_VERTICES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;

   // Fixed field widths.
   localparam int IDX_W = 6;
   localparam int WORD_W = 32;
   localparam int SUM_W = 48;

   // Divider sizing: magnitude width of operands, working width, quotient width.
   localparam int DIV_NW = 56;
   localparam int DIV_DW = DIV_NW + 32;
   localparam int DIV_QW = 31;

   // Request actions.
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TRI = 2'd1;
   localparam logic [1:0] ACT_FIN = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
      logic signed [WORD_W-1:0] nrm_x;
      logic signed [WORD_W-1:0] nrm_y;
      logic signed [WORD_W-1:0] nrm_z;
      logic signed [WORD_W-1:0] tex_u;
      logic signed [WORD_W-1:0] tex_v;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] vertex_index;
      logic signed [WORD_W-1:0] tan_x;
      logic signed [WORD_W-1:0] tan_y;
      logic signed [WORD_W-1:0] tan_z;
      logic fault_seen;
      logic last;
   } rsp_type;

   // One vertex entry of the vertex memory.
   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
      logic signed [WORD_W-1:0] nrm_x;
      logic signed [WORD_W-1:0] nrm_y;
      logic signed [WORD_W-1:0] nrm_z;
      logic signed [WORD_W-1:0] tex_u;
      logic signed [WORD_W-1:0] tex_v;
   } vtx_type;

   // One entry of the tangent sum memory.
   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_type;

   // Clamp a wide signed value to 32 bits.
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] x);
      logic in_range;
      in_range = (x[65:31] == '0) || (x[65:31] == '1);
      if (in_range) begin
         return x[WORD_W-1:0];
      end else if (x[65]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   // Clamp a 49-bit sum to 48 bits.
   function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] x);
      if (x[SUM_W] == x[SUM_W-1]) begin
         return x[SUM_W-1:0];
      end else if (x[SUM_W]) begin
         return {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SUM_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

### src/mvta_ram.sv
// Simple dual-port synchronous memory with a registered read port.
`default_nettype none

module mvta_ram #(
   parameter int WIDTH = mvta_pkg::WORD_W,
   parameter int DEPTH = mvta_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/mvta_div.sv
// Restoring fixed-point divider: quotient of num * 2^FRAC_BITS / den with overflow flag.
`default_nettype none

module mvta_div #(
   parameter int FRAC_BITS = mvta_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mvta_pkg::DIV_NW-1:0]   num,
   input  wire logic [mvta_pkg::DIV_NW-1:0]   den,
   output logic                               done,
   output logic      [mvta_pkg::DIV_QW-1:0]   quo,
   output logic                               sat
);

   localparam int DW = mvta_pkg::DIV_DW;
   localparam int QW = mvta_pkg::DIV_QW;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_CHK = 2'd1;
   localparam logic [1:0] D_RUN = 2'd2;

   logic [1:0]    dstate_ff, dstate_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          sat_ff, sat_in;
   logic          ge;

   assign ge = rem_ff >= dvs_ff;

   // One quotient bit per cycle after an overflow check.
   always_comb begin
      dstate_in = dstate_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      sat_in = sat_ff;
      case (dstate_ff)
         D_IDLE: begin
            if (start) begin
               rem_in = DW'(num) << FRAC_BITS;
               dvs_in = DW'(den) << QW;
               dstate_in = D_CHK;
            end
         end
         D_CHK: begin
            if (ge) begin
               sat_in = 1'b1;
               done_in = 1'b1;
               dstate_in = D_IDLE;
            end else begin
               sat_in = 1'b0;
               quo_in = '0;
               dvs_in = dvs_ff >> 1;
               cnt_in = '0;
               dstate_in = D_RUN;
            end
         end
         D_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in = {quo_ff[QW-2:0], ge};
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(QW - 1)) begin
               done_in = 1'b1;
               dstate_in = D_IDLE;
            end
         end
         default: begin
            dstate_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= D_IDLE;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

`default_nettype wire

### src/mvta_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none

module mvta_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic      [31:0] root
);

   logic        run_ff, run_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;
   logic        ge;

   assign trial = res_ff + bit_ff;
   assign ge = rem_ff >= trial;

   // Thirty-two steps, from the top bit pair down.
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (!run_ff) begin
         if (start) begin
            rem_in = radicand;
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = '0;
            run_in = 1'b1;
         end
      end else begin
         if (ge) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

### src/mesh_vertex_tangent_accumulate_unit.sv
// Top level of the per-vertex tangent accumulator: sequencer, shared multiplier and memories.
//
// Usage: a request word is taken when start is high and busy is low. Its action
// loads a vertex, adds a triangle's face tangent to its three corners, or
// finishes the mesh. A load leaves busy low. A triangle
// reads its three vertices from the vertex memory, runs eight products through
// the shared multiplier and three divisions, then read-modify-writes the three
// corner sums in the sum memory. A zero determinant ends it early with the fault
// flag set, and a division that saturates ends early.
// A triangle with a corner out of range is dropped and sets the fault flag.
// Finish emits one response word per loaded vertex, in index order, each on
// rsp_valid for exactly one cycle; the receiver cannot hold them off. Per
// vertex, the rescaling shifts, the square root and the three divisions run
// one after the other.
// Reset clears the vertex count and the fault flag; memory contents are kept.
`default_nettype none

module mesh_vertex_tangent_accumulate_unit #(
   parameter int MAX_VERTICES = mvta_pkg::MAX_VERTICES_DEF,
   parameter int FRAC_BITS = mvta_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mvta_pkg::req_type req_data,
   output logic                   rsp_valid,
   output mvta_pkg::rsp_type      rsp_data
);

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = mvta_pkg::IDX_W + 1;
   localparam int SHP_W = mvta_pkg::DIV_NW;
   localparam int NUM_W = mvta_pkg::DIV_NW + 1;
   localparam int NW = mvta_pkg::DIV_NW;
   localparam logic [47:0] NORM_HI = 48'h0000_4000_0000;
   localparam logic [47:0] NORM_LO = 48'h0000_2000_0000;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TRD = 4'd1;
   localparam logic [3:0] S_TMUL = 4'd2;
   localparam logic [3:0] S_TDIV = 4'd3;
   localparam logic [3:0] S_TSUM = 4'd4;
   localparam logic [3:0] S_FRD = 4'd5;
   localparam logic [3:0] S_FCAP = 4'd6;
   localparam logic [3:0] S_FNORM = 4'd7;
   localparam logic [3:0] S_FSQ = 4'd8;
   localparam logic [3:0] S_FSQRT = 4'd9;
   localparam logic [3:0] S_FDIV = 4'd10;
   localparam logic [3:0] S_FDOT = 4'd11;
   localparam logic [3:0] S_FPRJ = 4'd12;
   localparam logic [3:0] S_FOUT = 4'd13;

   // Control state.
   logic [3:0]     state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   logic [1:0]     k_ff, k_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           fault_ff, fault_in;
   logic [VAW-1:0] v_ff, v_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [VAW-1:0]     idx_ff [3], idx_in [3];
   logic signed [31:0] pa_ff [3], pa_in [3];
   logic signed [31:0] ua_ff, ua_in, va_ff, va_in;
   logic signed [31:0] e1_ff [3], e1_in [3];
   logic signed [31:0] e2_ff [3], e2_in [3];
   logic signed [31:0] du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [31:0] du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [SHP_W-1:0] hold_ff, hold_in;
   logic signed [NUM_W-1:0] det_ff, det_in;
   logic signed [NUM_W-1:0] num_ff [3], num_in [3];
   logic signed [31:0] t_ff [3], t_in [3];
   logic signed [47:0] c_ff [3], c_in [3];
   logic signed [31:0] n_ff [3], n_in [3];
   logic [47:0]        m_ff, m_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [31:0]        len_ff, len_in;
   logic signed [31:0] u_ff [3], u_in [3];
   logic signed [31:0] dot_ff, dot_in;
   mvta_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic              vwe, vre, swe, sre;
   logic [VAW-1:0]    vwa, vra, swa, sra;
   mvta_pkg::vtx_type vwd, vrd;
   mvta_pkg::sum_type swd, srd;

   // Shared units.
   logic signed [31:0] mul_a, mul_b;
   logic               div_start, div_done, div_sat;
   logic [NW-1:0]      div_num, div_den;
   logic [30:0]        div_quo;
   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;

   // Helpers.
   logic signed [SHP_W-1:0] sh;
   logic signed [NUM_W-1:0] diff;
   logic signed [NUM_W-1:0] num_sel;
   logic signed [47:0]      c_sel;
   logic [NW-1:0]           tnum, tden, fnum;
   logic                    neg_t;
   logic signed [31:0]      q32;
   logic [47:0]             cm [3];
   logic [47:0]             m_max;
   logic signed [63:0]      acc_sum;
   logic signed [63:0]      prj;
   logic                    bad_tri;
   logic                    is_last;

   assign sh = SHP_W'(prod_ff >>> FRAC_BITS);
   assign diff = NUM_W'(hold_ff) - NUM_W'(sh);
   assign num_sel = num_ff[k_ff];
   assign c_sel = c_ff[k_ff];
   assign tnum = num_sel[NUM_W-1] ? NW'(-num_sel) : NW'(num_sel);
   assign tden = det_ff[NUM_W-1] ? NW'(-det_ff) : NW'(det_ff);
   assign fnum = c_sel[47] ? NW'(-c_sel) : NW'(c_sel);
   assign neg_t = num_sel[NUM_W-1] ^ det_ff[NUM_W-1];
   assign q32 = {1'b0, div_quo};
   assign acc_sum = acc_ff + prod_ff;
   assign prj = prod_ff >>> FRAC_BITS;
   assign is_last = (CW'(v_ff) == count_ff - CW'(1));

   assign bad_tri = (CMP_W'(req_data.corner_a) >= CMP_W'(count_ff)) ||
                    (CMP_W'(req_data.corner_b) >= CMP_W'(count_ff)) ||
                    (CMP_W'(req_data.corner_c) >= CMP_W'(count_ff));

   // Magnitudes of the loaded sum and their maximum.
   always_comb begin
      cm[0] = srd.x[47] ? 48'(-srd.x) : 48'(srd.x);
      cm[1] = srd.y[47] ? 48'(-srd.y) : 48'(srd.y);
      cm[2] = srd.z[47] ? 48'(-srd.z) : 48'(srd.z);
      m_max = cm[0];
      if (cm[1] > m_max) begin
         m_max = cm[1];
      end
      if (cm[2] > m_max) begin
         m_max = cm[2];
      end
   end

   // Divider operands: face numerator over determinant, or sum component over length.
   assign div_num = (state_ff == S_FDIV) ? fnum : tnum;
   assign div_den = (state_ff == S_FDIV) ? NW'(len_ff) : tden;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_TMUL: begin
            case (step_ff)
               4'd0: begin mul_a = du1_ff; mul_b = dv2_ff; end
               4'd1: begin mul_a = du2_ff; mul_b = dv1_ff; end
               4'd2: begin mul_a = dv2_ff; mul_b = e1_ff[0]; end
               4'd3: begin mul_a = dv1_ff; mul_b = e2_ff[0]; end
               4'd4: begin mul_a = dv2_ff; mul_b = e1_ff[1]; end
               4'd5: begin mul_a = dv1_ff; mul_b = e2_ff[1]; end
               4'd6: begin mul_a = dv2_ff; mul_b = e1_ff[2]; end
               4'd7: begin mul_a = dv1_ff; mul_b = e2_ff[2]; end
               default: ;
            endcase
         end
         S_FSQ: begin
            case (step_ff)
               4'd0: begin mul_a = 32'(c_ff[0]); mul_b = 32'(c_ff[0]); end
               4'd1: begin mul_a = 32'(c_ff[1]); mul_b = 32'(c_ff[1]); end
               4'd2: begin mul_a = 32'(c_ff[2]); mul_b = 32'(c_ff[2]); end
               default: ;
            endcase
         end
         S_FDOT: begin
            case (step_ff)
               4'd0: begin mul_a = n_ff[0]; mul_b = u_ff[0]; end
               4'd1: begin mul_a = n_ff[1]; mul_b = u_ff[1]; end
               4'd2: begin mul_a = n_ff[2]; mul_b = u_ff[2]; end
               default: ;
            endcase
         end
         S_FPRJ: begin
            case (step_ff)
               4'd0: begin mul_a = n_ff[0]; mul_b = dot_ff; end
               4'd1: begin mul_a = n_ff[1]; mul_b = dot_ff; end
               4'd2: begin mul_a = n_ff[2]; mul_b = dot_ff; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      k_in = k_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      v_in = v_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      idx_in = idx_ff;
      pa_in = pa_ff;
      ua_in = ua_ff;
      va_in = va_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      du1_in = du1_ff;
      dv1_in = dv1_ff;
      du2_in = du2_ff;
      dv2_in = dv2_ff;
      hold_in = hold_ff;
      det_in = det_ff;
      num_in = num_ff;
      t_in = t_ff;
      c_in = c_ff;
      n_in = n_ff;
      m_in = m_ff;
      acc_in = acc_ff;
      len_in = len_ff;
      u_in = u_ff;
      dot_in = dot_ff;
      vwe = 1'b0;
      vwa = count_ff[VAW-1:0];
      vwd.pos_x = req_data.pos_x;
      vwd.pos_y = req_data.pos_y;
      vwd.pos_z = req_data.pos_z;
      vwd.nrm_x = req_data.nrm_x;
      vwd.nrm_y = req_data.nrm_y;
      vwd.nrm_z = req_data.nrm_z;
      vwd.tex_u = req_data.tex_u;
      vwd.tex_v = req_data.tex_v;
      vre = 1'b0;
      vra = v_ff;
      swe = 1'b0;
      swa = count_ff[VAW-1:0];
      swd = '0;
      sre = 1'b0;
      sra = v_ff;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.action)
                  mvta_pkg::ACT_LOAD: begin
                     if (count_ff != CW'(MAX_VERTICES)) begin
                        vwe = 1'b1;
                        swe = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  mvta_pkg::ACT_TRI: begin
                     if (bad_tri) begin
                        fault_in = 1'b1;
                     end else begin
                        idx_in[0] = req_data.corner_a[VAW-1:0];
                        idx_in[1] = req_data.corner_b[VAW-1:0];
                        idx_in[2] = req_data.corner_c[VAW-1:0];
                        step_in = '0;
                        state_in = S_TRD;
                     end
                  end
                  mvta_pkg::ACT_FIN: begin
                     if (count_ff != '0) begin
                        v_in = '0;
                        state_in = S_FRD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Read the three corners and form edge and texture deltas.
         S_TRD: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  vre = 1'b1;
                  vra = idx_ff[0];
               end
               4'd1: begin
                  vre = 1'b1;
                  vra = idx_ff[1];
                  pa_in[0] = vrd.pos_x;
                  pa_in[1] = vrd.pos_y;
                  pa_in[2] = vrd.pos_z;
                  ua_in = vrd.tex_u;
                  va_in = vrd.tex_v;
               end
               4'd2: begin
                  vre = 1'b1;
                  vra = idx_ff[2];
                  e1_in[0] = mvta_pkg::sat32(66'(vrd.pos_x) - 66'(pa_ff[0]));
                  e1_in[1] = mvta_pkg::sat32(66'(vrd.pos_y) - 66'(pa_ff[1]));
                  e1_in[2] = mvta_pkg::sat32(66'(vrd.pos_z) - 66'(pa_ff[2]));
                  du1_in = mvta_pkg::sat32(66'(vrd.tex_u) - 66'(ua_ff));
                  dv1_in = mvta_pkg::sat32(66'(vrd.tex_v) - 66'(va_ff));
               end
               default: begin
                  e2_in[0] = mvta_pkg::sat32(66'(vrd.pos_x) - 66'(pa_ff[0]));
                  e2_in[1] = mvta_pkg::sat32(66'(vrd.pos_y) - 66'(pa_ff[1]));
                  e2_in[2] = mvta_pkg::sat32(66'(vrd.pos_z) - 66'(pa_ff[2]));
                  du2_in = mvta_pkg::sat32(66'(vrd.tex_u) - 66'(ua_ff));
                  dv2_in = mvta_pkg::sat32(66'(vrd.tex_v) - 66'(va_ff));
                  step_in = '0;
                  state_in = S_TMUL;
               end
            endcase
         end

         // Determinant and three numerators, one product per cycle.
         S_TMUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               if (step_ff[0]) begin
                  hold_in = sh;
               end else begin
                  case (step_ff)
                     4'd2: det_in = diff;
                     4'd4: num_in[0] = diff;
                     4'd6: num_in[1] = diff;
                     default: num_in[2] = diff;
                  endcase
               end
            end
            if (step_ff == 4'd8) begin
               step_in = '0;
               k_in = '0;
               if (det_ff == '0) begin
                  fault_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_TDIV;
               end
            end
         end

         // Face tangent components through the divider.
         S_TDIV: begin
            if (step_ff == 4'd0) begin
               div_start = 1'b1;
               step_in = 4'd1;
            end else if (div_done) begin
               if (div_sat) begin
                  t_in[k_ff] = neg_t ? 32'sh8000_0000 : 32'sh7fff_ffff;
               end else begin
                  t_in[k_ff] = neg_t ? -q32 : q32;
               end
               step_in = '0;
               if (k_ff == 2'd2) begin
                  k_in = '0;
                  state_in = S_TSUM;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end

         // Read-modify-write of each corner sum; the write lands before the next read.
         S_TSUM: begin
            sra = idx_ff[k_ff];
            swa = idx_ff[k_ff];
            if (step_ff == 4'd0) begin
               sre = 1'b1;
               step_in = 4'd1;
            end else begin
               swe = 1'b1;
               swd.x = mvta_pkg::sat48(49'(srd.x) + 49'(t_ff[0]));
               swd.y = mvta_pkg::sat48(49'(srd.y) + 49'(t_ff[1]));
               swd.z = mvta_pkg::sat48(49'(srd.z) + 49'(t_ff[2]));
               step_in = '0;
               if (k_ff == 2'd2) begin
                  k_in = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end

         S_FRD: begin
            vre = 1'b1;
            sre = 1'b1;
            state_in = S_FCAP;
         end

         S_FCAP: begin
            c_in[0] = srd.x;
            c_in[1] = srd.y;
            c_in[2] = srd.z;
            n_in[0] = vrd.nrm_x;
            n_in[1] = vrd.nrm_y;
            n_in[2] = vrd.nrm_z;
            m_in = m_max;
            if (m_max == '0) begin
               t_in[0] = '0;
               t_in[1] = '0;
               t_in[2] = '0;
               state_in = S_FOUT;
            end else begin
               state_in = S_FNORM;
            end
         end

         // Scale the sum one bit per cycle until its largest magnitude is in range.
         S_FNORM: begin
            if (m_ff >= NORM_HI) begin
               c_in[0] = c_ff[0] >>> 1;
               c_in[1] = c_ff[1] >>> 1;
               c_in[2] = c_ff[2] >>> 1;
               m_in = m_ff >> 1;
            end else if (m_ff < NORM_LO) begin
               c_in[0] = c_ff[0] <<< 1;
               c_in[1] = c_ff[1] <<< 1;
               c_in[2] = c_ff[2] <<< 1;
               m_in = m_ff << 1;
            end else begin
               acc_in = '0;
               step_in = '0;
               state_in = S_FSQ;
            end
         end

         // Sum of squares, then the square root.
         S_FSQ: begin
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0 && step_ff != 4'd4) begin
               acc_in = acc_sum;
            end
            if (step_ff == 4'd4) begin
               sqrt_start = 1'b1;
               state_in = S_FSQRT;
            end
         end

         S_FSQRT: begin
            if (sqrt_done) begin
               len_in = sqrt_root;
               k_in = '0;
               step_in = '0;
               state_in = S_FDIV;
            end
         end

         // Unit vector components through the divider.
         S_FDIV: begin
            if (step_ff == 4'd0) begin
               div_start = 1'b1;
               step_in = 4'd1;
            end else if (div_done) begin
               u_in[k_ff] = c_sel[47] ? -q32 : q32;
               step_in = '0;
               if (k_ff == 2'd2) begin
                  k_in = '0;
                  acc_in = '0;
                  state_in = S_FDOT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end

         // Dot product of normal and unit vector.
         S_FDOT: begin
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               acc_in = acc_sum;
            end
            if (step_ff == 4'd3) begin
               dot_in = mvta_pkg::sat32(66'(acc_sum >>> FRAC_BITS));
               step_in = '0;
               state_in = S_FPRJ;
            end
         end

         // Remove the projection on the normal.
         S_FPRJ: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd1: t_in[0] = mvta_pkg::sat32(66'(u_ff[0]) - 66'(prj));
               4'd2: t_in[1] = mvta_pkg::sat32(66'(u_ff[1]) - 66'(prj));
               4'd3: begin
                  t_in[2] = mvta_pkg::sat32(66'(u_ff[2]) - 66'(prj));
                  step_in = '0;
                  state_in = S_FOUT;
               end
               default: ;
            endcase
         end

         // Emit the word for this vertex.
         S_FOUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.vertex_index = mvta_pkg::IDX_W'(v_ff);
            rsp_data_in.tan_x = t_ff[0];
            rsp_data_in.tan_y = t_ff[1];
            rsp_data_in.tan_z = t_ff[2];
            rsp_data_in.fault_seen = fault_ff;
            rsp_data_in.last = is_last;
            if (is_last) begin
               count_in = '0;
               fault_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               v_in = v_ff + VAW'(1);
               state_in = S_FRD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         k_ff <= '0;
         count_ff <= '0;
         fault_ff <= 1'b0;
         v_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         k_ff <= k_in;
         count_ff <= count_in;
         fault_ff <= fault_in;
         v_ff <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pa_ff <= pa_in;
      ua_ff <= ua_in;
      va_ff <= va_in;
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      du1_ff <= du1_in;
      dv1_ff <= dv1_in;
      du2_ff <= du2_in;
      dv2_ff <= dv2_in;
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      det_ff <= det_in;
      num_ff <= num_in;
      t_ff <= t_in;
      c_ff <= c_in;
      n_ff <= n_in;
      m_ff <= m_in;
      acc_ff <= acc_in;
      len_ff <= len_in;
      u_ff <= u_in;
      dot_ff <= dot_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Vertex memory: position, normal and texture coordinate per vertex.
   mvta_ram #(
      .WIDTH($bits(mvta_pkg::vtx_type)),
      .DEPTH(MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vwe),
      .wr_addr (vwa),
      .wr_data (vwd),
      .rd_en   (vre),
      .rd_addr (vra),
      .rd_data (vrd)
   );

   // Tangent sum memory.
   mvta_ram #(
      .WIDTH($bits(mvta_pkg::sum_type)),
      .DEPTH(MAX_VERTICES)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (swe),
      .wr_addr (swa),
      .wr_data (swd),
      .rd_en   (sre),
      .rd_addr (sra),
      .rd_data (srd)
   );

   mvta_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .sat   (div_sat)
   );

   mvta_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (64'(acc_ff)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

### dv/tb_mesh_vertex_tangent_accumulate_unit.sv
// Self-checking testbench for the per-vertex tangent accumulator.
`timescale 1ns / 1ps

module tb_mesh_vertex_tangent_accumulate_unit;

   localparam int FRAC = mvta_pkg::FRAC_BITS_DEF;
   localparam int VMAX = mvta_pkg::MAX_VERTICES_DEF;
   localparam int IDXW = mvta_pkg::IDX_W;
   localparam int WORDW = mvta_pkg::WORD_W;
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S48_MAX = 64'sd140737488355327;
   localparam longint S48_MIN = -64'sd140737488355328;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mvta_pkg::req_type req_data;
   logic              rsp_valid;
   mvta_pkg::rsp_type rsp_data;

   mesh_vertex_tangent_accumulate_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Mirror of the block's mesh state.
   longint  mesh_pos[VMAX][3];
   longint  mesh_nrm[VMAX][3];
   longint  mesh_uv[VMAX][2];
   longint  mesh_sum[VMAX][3];
   int      mesh_count;
   bit      mesh_fault;

   mvta_pkg::rsp_type tangent_queue[$];
   int      mismatch_count;
   int      words_sent;
   int      words_seen;
   int      send_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_to(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   // Fixed-point quotient num * 2^F / den, truncated toward zero and saturated.
   function automatic longint face_quotient(longint num, longint den);
      longint unsigned n, d, q, r;
      bit neg;
      n = magnitude(num);
      d = magnitude(den);
      q = n / d;
      r = n % d;
      neg = (num < 0) != (den < 0);
      if (q >= (64'd1 << (31 - FRAC))) return neg ? S32_MIN : S32_MAX;
      q = q << FRAC;
      for (int i = FRAC; i > 0; i--) begin
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << (i - 1));
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v = v - (res + bit_pos);
            res = (res >> 1) + bit_pos;
         end else begin
            res = res >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return res;
   endfunction

   // Face tangent added to the three corner sums; degenerate faces set the fault.
   task automatic add_face_tangent(int a, int b, int c);
      longint e1[3], e2[3], t[3];
      longint du1, dv1, du2, dv2, det;
      int corner[3];
      for (int k = 0; k < 3; k++) begin
         e1[k] = clamp_to(mesh_pos[b][k] - mesh_pos[a][k], S32_MIN, S32_MAX);
         e2[k] = clamp_to(mesh_pos[c][k] - mesh_pos[a][k], S32_MIN, S32_MAX);
      end
      du1 = clamp_to(mesh_uv[b][0] - mesh_uv[a][0], S32_MIN, S32_MAX);
      dv1 = clamp_to(mesh_uv[b][1] - mesh_uv[a][1], S32_MIN, S32_MAX);
      du2 = clamp_to(mesh_uv[c][0] - mesh_uv[a][0], S32_MIN, S32_MAX);
      dv2 = clamp_to(mesh_uv[c][1] - mesh_uv[a][1], S32_MIN, S32_MAX);
      det = ((du1 * dv2) >>> FRAC) - ((du2 * dv1) >>> FRAC);
      if (det == 0) begin
         mesh_fault = 1'b1;
         return;
      end
      for (int k = 0; k < 3; k++)
         t[k] = face_quotient(((dv2 * e1[k]) >>> FRAC) - ((dv1 * e2[k]) >>> FRAC), det);
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      for (int j = 0; j < 3; j++)
         for (int k = 0; k < 3; k++)
            mesh_sum[corner[j]][k] = clamp_to(mesh_sum[corner[j]][k] + t[k], S48_MIN, S48_MAX);
   endtask

   // Normalized sum with its projection on the normal removed.
   function automatic mvta_pkg::rsp_type vertex_tangent(int v, bit is_last);
      longint c[3], u[3], t[3], dot;
      longint unsigned m, sq, len, q;
      int sh;
      mvta_pkg::rsp_type r;
      m = 0;
      sq = 0;
      sh = 0;
      for (int k = 0; k < 3; k++) begin
         c[k] = mesh_sum[v][k];
         if (magnitude(c[k]) > m) m = magnitude(c[k]);
      end
      if (m == 0) begin
         u = '{0, 0, 0};
      end else begin
         if (m >= (64'd1 << 30)) begin
            while ((m >> sh) >= (64'd1 << 30)) sh++;
            for (int k = 0; k < 3; k++) c[k] = c[k] >>> sh;
         end else begin
            while ((m << sh) < (64'd1 << 29)) sh++;
            for (int k = 0; k < 3; k++) c[k] = c[k] * (64'sd1 << sh);
         end
         for (int k = 0; k < 3; k++) sq = sq + longint'(c[k] * c[k]);
         len = int_sqrt(sq);
         for (int k = 0; k < 3; k++) begin
            q = (magnitude(c[k]) << FRAC) / len;
            u[k] = c[k] < 0 ? -longint'(q) : longint'(q);
         end
      end
      dot = 0;
      for (int k = 0; k < 3; k++) dot = dot + mesh_nrm[v][k] * u[k];
      dot = clamp_to(dot >>> FRAC, S32_MIN, S32_MAX);
      for (int k = 0; k < 3; k++)
         t[k] = clamp_to(u[k] - ((mesh_nrm[v][k] * dot) >>> FRAC), S32_MIN, S32_MAX);
      r.vertex_index = v[IDXW-1:0];
      r.tan_x = t[0][WORDW-1:0];
      r.tan_y = t[1][WORDW-1:0];
      r.tan_z = t[2][WORDW-1:0];
      r.fault_seen = mesh_fault;
      r.last = is_last;
      return r;
   endfunction

   // Update the mirror for one accepted word and queue the tangents it produces.
   task automatic predict_word(mvta_pkg::req_type w);
      int v;
      case (w.action)
         mvta_pkg::ACT_LOAD: begin
            if (mesh_count < VMAX) begin
               v = mesh_count;
               mesh_pos[v] = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
               mesh_nrm[v] = '{longint'(w.nrm_x), longint'(w.nrm_y), longint'(w.nrm_z)};
               mesh_uv[v] = '{longint'(w.tex_u), longint'(w.tex_v)};
               mesh_sum[v] = '{0, 0, 0};
               mesh_count++;
            end
         end
         mvta_pkg::ACT_TRI: begin
            if (int'(w.corner_a) >= mesh_count || int'(w.corner_b) >= mesh_count ||
                int'(w.corner_c) >= mesh_count) begin
               mesh_fault = 1'b1;
            end else begin
               add_face_tangent(int'(w.corner_a), int'(w.corner_b), int'(w.corner_c));
            end
         end
         mvta_pkg::ACT_FIN: begin
            if (mesh_count != 0) begin
               for (int k = 0; k < mesh_count; k++)
                  tangent_queue.push_back(vertex_tangent(k, k + 1 == mesh_count));
               mesh_count = 0;
               mesh_fault = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // Send one word; start stays high so back-to-back words need no gap.
   task automatic send_word(mvta_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      words_sent++;
      predict_word(w);
   endtask

   // Sender holds off until every queued tangent has come back.
   task automatic wait_all_tangents();
      start <= 1'b0;
      @(posedge clock);
      while (tangent_queue.size() != 0) @(posedge clock);
   endtask

   function automatic mvta_pkg::req_type noise_word(logic [1:0] act);
      logic [287:0] raw;
      mvta_pkg::req_type w;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      w = raw[$bits(mvta_pkg::req_type)-1:0];
      w.action = act;
      return w;
   endfunction

   function automatic mvta_pkg::req_type vertex_word();
      mvta_pkg::req_type w;
      w = noise_word(mvta_pkg::ACT_LOAD);
      if ($urandom_range(9) != 0) begin
         w.pos_x = $urandom_range(32'h0020_0000) - 32'h0010_0000;
         w.pos_y = $urandom_range(32'h0020_0000) - 32'h0010_0000;
         w.pos_z = $urandom_range(32'h0020_0000) - 32'h0010_0000;
         w.nrm_x = $urandom_range(32'h0002_0000) - 32'h0001_0000;
         w.nrm_y = $urandom_range(32'h0002_0000) - 32'h0001_0000;
         w.nrm_z = $urandom_range(32'h0002_0000) - 32'h0001_0000;
         w.tex_u = $urandom_range(32'h0004_0000) - 32'h0002_0000;
         w.tex_v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      end
      return w;
   endfunction

   function automatic mvta_pkg::req_type tri_word(int a, int b, int c);
      mvta_pkg::req_type w;
      w = noise_word(mvta_pkg::ACT_TRI);
      w.corner_a = a[IDXW-1:0];
      w.corner_b = b[IDXW-1:0];
      w.corner_c = c[IDXW-1:0];
      return w;
   endfunction

   // Action three and a finish with no vertices: neither yields a word.
   task automatic test_no_result_actions();
      send_word(noise_word(ACT_NONE));
      send_word(noise_word(mvta_pkg::ACT_FIN));
      send_word(noise_word(ACT_NONE));
   endtask

   // Extreme field values, degenerate and out-of-range faces, an untouched vertex.
   task automatic test_extremes();
      mvta_pkg::req_type w;
      w = noise_word(mvta_pkg::ACT_LOAD);
      w.pos_x = 32'h7FFF_FFFF; w.pos_y = 32'h8000_0000; w.pos_z = 32'h7FFF_FFFF;
      w.nrm_x = 32'h8000_0000; w.nrm_y = 32'h7FFF_FFFF; w.nrm_z = 32'h0001_0000;
      w.tex_u = 32'h7FFF_FFFF; w.tex_v = 32'h8000_0000;
      send_word(w);
      w.pos_x = 32'h8000_0000; w.pos_y = 32'h7FFF_FFFF; w.pos_z = 32'h0000_0000;
      w.nrm_x = 32'h7FFF_FFFF; w.nrm_y = 32'h8000_0000; w.nrm_z = 32'hFFFF_FFFF;
      w.tex_u = 32'h8000_0000; w.tex_v = 32'h8000_0000;
      send_word(w);
      w = '0;
      w.action = mvta_pkg::ACT_LOAD;
      w.nrm_z = 32'h0001_0000;
      w.tex_v = 32'h7FFF_FFFF;
      send_word(w);
      w.pos_x = 32'h0001_0000; w.tex_u = 32'h0001_0000; w.tex_v = 32'h0000_0000;
      send_word(w);
      w.pos_y = 32'h0001_0000; w.tex_v = 32'h0001_0000; w.nrm_x = 32'hFFFF_0000;
      send_word(w);
      send_word(vertex_word());
      send_word(tri_word(0, 1, 2));
      send_word(tri_word(2, 3, 4));
      send_word(tri_word(4, 3, 2));
      send_word(tri_word(0, 1, 63));
      send_word(tri_word(6, 0, 1));
      send_word(noise_word(mvta_pkg::ACT_FIN));
      // A degenerate face alone also raises the fault on a fresh mesh.
      for (int i = 0; i < 3; i++) send_word(vertex_word());
      send_word(tri_word(1, 1, 2));
      send_word(tri_word(0, 1, 2));
      send_word(noise_word(mvta_pkg::ACT_FIN));
      wait_all_tangents();
   endtask

   // A full vertex store, a load past the end, then faces on the last entries.
   task automatic test_full_mesh();
      for (int i = 0; i < VMAX + 1; i++) send_word(vertex_word());
      send_word(tri_word(VMAX - 1, 0, VMAX - 2));
      send_word(tri_word(5, 40, 63));
      send_word(noise_word(mvta_pkg::ACT_FIN));
   endtask

   // Random meshes: mostly well-formed faces, with some bad ones and noise.
   task automatic test_random_meshes(int idle_pct, int word_budget);
      int sent, verts, pick;
      sent = 0;
      send_idle_pct = idle_pct;
      while (sent < word_budget) begin
         verts = ($urandom_range(7) == 0) ? $urandom_range(11, 20) : $urandom_range(3, 8);
         for (int i = 0; i < verts; i++) begin
            send_word(vertex_word());
            sent++;
         end
         for (int i = 0; i < verts + $urandom_range(4); i++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               send_word(tri_word($urandom_range(verts - 1), $urandom_range(verts - 1),
                                  $urandom_range(verts - 1)));
            end else if (pick < 87) begin
               send_word(tri_word($urandom_range(63), $urandom_range(63), $urandom_range(63)));
            end else if (pick < 93) begin
               send_word(noise_word(ACT_NONE));
            end else begin
               send_word(vertex_word());
            end
            sent++;
         end
         send_word(noise_word(mvta_pkg::ACT_FIN));
         sent++;
      end
   endtask

   // Every tangent word is compared against the oldest prediction.
   always @(negedge clock) begin
      mvta_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (tangent_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected tangent word: %h", rsp_data);
         end else begin
            want = tangent_queue.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want %0d (%h %h %h) %b%b got %0d (%h %h %h) %b%b",
                           want.vertex_index, want.tan_x, want.tan_y, want.tan_z,
                           want.fault_seen, want.last, rsp_data.vertex_index, rsp_data.tan_x,
                           rsp_data.tan_y, rsp_data.tan_z, rsp_data.fault_seen, rsp_data.last);
            end
         end
      end
   end

   // Watchdog: too long without any word moving ends the run.
   always @(negedge clock) begin
      int quiet, last_moved;
      if (words_sent + words_seen != last_moved) begin
         quiet = 0;
         last_moved = words_sent + words_seen;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("mesh_vertex_tangent_accumulate_unit verification failed");
         $finish;
      end
   end

   initial begin
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      mesh_count = 0;
      mesh_fault = 1'b0;
      mismatch_count = 0;
      words_sent = 0;
      words_seen = 0;
      send_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_result_actions();
      test_extremes();
      test_full_mesh();
      test_random_meshes(28, 60);
      wait_all_tangents();
      test_random_meshes(73, 60);
      test_random_meshes(0, 60);

      start <= 1'b0;
      @(posedge clock);
      while (tangent_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && tangent_queue.size() == 0) begin
         $display("mesh_vertex_tangent_accumulate_unit verification clean");
      end else begin
         $display("mesh_vertex_tangent_accumulate_unit verification failed");
      end
      $finish;
   end

endmodule
